[rtl/ifcc_pkg.sv]
`timescale 1ns / 1ps
// Package: frame layout constants, result type and CRC-32 column table.
package ifcc_pkg;

    localparam int unsigned WORD_W     = 16;
    localparam int unsigned IDX_W      = 5;
    localparam int unsigned SLOT_W     = 4;
    localparam int unsigned CRC_W      = 32;
    localparam int unsigned COL_N      = CRC_W + WORD_W;

    localparam logic [CRC_W-1:0] CRC_POLY = 32'hEDB8_8320;
    localparam logic [CRC_W-1:0] CRC_INIT = 32'hFFFF_FFFF;

    localparam logic [IDX_W-1:0] FRAME_WORDS   = 5'd19;
    localparam logic [IDX_W-1:0] CRC_FIRST     = 5'd2;
    localparam logic [IDX_W-1:0] CRC_LAST      = 5'd16;
    localparam logic [IDX_W-1:0] RXCRC_LOW_IDX = 5'd17;
    localparam logic [IDX_W-1:0] LAST_WORD     = 5'd18;
    localparam logic [IDX_W-1:0] SLOT_SPECIAL  = 5'd3;
    localparam logic [IDX_W-1:0] SLOT_FIRST    = 5'd4;
    localparam logic [IDX_W-1:0] SLOT_LAST     = 5'd15;
    localparam logic [IDX_W-1:0] SLOT_OFFSET   = 5'd3;
    localparam logic [SLOT_W-1:0] SLOT_OF_WORD3 = 4'd13;

    typedef logic [COL_N-1:0][CRC_W-1:0] t_crc_cols;

    typedef struct packed {
        logic [WORD_W-1:0] out_word;
        logic [SLOT_W-1:0] slot;
        logic              slot_valid;
        logic              frame_done;
        logic              crc_ok;
    } t_result;

    // Bitwise reflected CRC over one 16-bit word, low byte first.
    // Elaboration only: builds the column table below.
    function automatic logic [CRC_W-1:0] crc16_serial(
        input logic [CRC_W-1:0]  crc,
        input logic [WORD_W-1:0] w
    );
        logic [CRC_W-1:0] c;
        c = crc;
        for (int b = 0; b < WORD_W; b++) begin
            c = c ^ {{(CRC_W-1){1'b0}}, w[b]};
            c = c[0] ? ((c >> 1) ^ CRC_POLY) : (c >> 1);
        end
        return c;
    endfunction

    // The word update is linear over GF(2): one column per state bit
    // and per data bit.
    function automatic t_crc_cols crc_cols();
        t_crc_cols cols;
        for (int j = 0; j < CRC_W; j++) begin
            cols[j] = crc16_serial(CRC_W'(1) << j, '0);
        end
        for (int k = 0; k < WORD_W; k++) begin
            cols[CRC_W+k] = crc16_serial('0, WORD_W'(1) << k);
        end
        return cols;
    endfunction

endpackage

[rtl/ifcc_channels.sv]
`timescale 1ns / 1ps
// Interfaces: input word channel and result word channel.
interface ifcc_in_if;
    logic                         valid;
    logic                         ready;
    logic [ifcc_pkg::WORD_W-1:0]  rx_word;
    logic                         frame_start;

    modport source (output valid, output rx_word, output frame_start, input ready);
    modport sink   (input valid, input rx_word, input frame_start, output ready);
endinterface

interface ifcc_out_if;
    logic                         valid;
    logic                         ready;
    logic [ifcc_pkg::WORD_W-1:0]  out_word;
    logic [ifcc_pkg::SLOT_W-1:0]  slot;
    logic                         slot_valid;
    logic                         frame_done;
    logic                         crc_ok;

    modport source (output valid, output out_word, output slot, output slot_valid,
                    output frame_done, output crc_ok, input ready);
    modport sink   (input valid, input out_word, input slot, input slot_valid,
                    input frame_done, input crc_ok, output ready);
endinterface

[rtl/imu_burst_frame_crc_checker_top.sv]
`timescale 1ns / 1ps
// Top level: burst frame CRC checker with input and result registers.
//
//  Channel  Dir  Payload                                          Accept
//  i_in     in   rx_word[15:0], frame_start                       valid & ready
//  o_out    out  out_word[15:0], slot[3:0], slot_valid,
//                frame_done, crc_ok                               valid & ready
//
// One word per cycle sustained while the sink keeps ready high. A word
// sits in the input register, the frame logic (parallel CRC-32 xor network,
// index and slot decode) is combinational, and the result register
// holds the outcome. Frame state updates when a word moves into the result
// register. Reset (synchronous, active low) empties both registers, clears the
// word index and presets the CRC to all ones. When the sink stalls, the input
// register still takes one more word; ready drops only when both registers are
// full.
module imu_burst_frame_crc_checker_top (
    input  logic           i_clk,
    input  logic           i_rst_n,
    ifcc_in_if.sink        i_in,
    ifcc_out_if.source     o_out
);

    // input register
    logic                         r_in_vld;
    logic [ifcc_pkg::WORD_W-1:0]  r_in_word;
    logic                         r_in_start;

    // result register
    logic                         r_out_vld;
    ifcc_pkg::t_result            r_out;

    logic                         advance;
    logic                         in_take;
    ifcc_pkg::t_result            result;
    logic [ifcc_pkg::IDX_W-1:0]   cur_index;

    assign advance    = r_in_vld && (!r_out_vld || o_out.ready);
    assign i_in.ready = !r_in_vld || advance;
    assign in_take    = i_in.valid && i_in.ready;

    ifcc_frame_ctrl u_frame (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_word    (r_in_word),
        .i_start   (r_in_start),
        .o_result  (result),
        .o_index   (cur_index)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_vld <= 1'b1;
            end else if (advance) begin
                r_in_vld <= 1'b0;
            end
            if (advance) begin
                r_out_vld <= 1'b1;
            end else if (o_out.ready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_word  <= i_in.rx_word;
            r_in_start <= i_in.frame_start;
        end
        if (advance) begin
            r_out <= result;
        end
    end

    assign o_out.valid      = r_out_vld;
    assign o_out.out_word   = r_out.out_word;
    assign o_out.slot       = r_out.slot;
    assign o_out.slot_valid = r_out.slot_valid;
    assign o_out.frame_done = r_out.frame_done;
    assign o_out.crc_ok     = r_out.crc_ok;

`ifndef ASSERT_OFF
    // the word index never leaves the frame
    a_index_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cur_index < ifcc_pkg::FRAME_WORDS)
        else $error("word index out of frame range");

    // a CRC pass only comes with the last word, which has no slot
    a_ok_with_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && r_out.crc_ok |-> r_out.frame_done && !r_out.slot_valid)
        else $error("crc_ok outside last word");

    // slot code and slot flag agree
    a_slot_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld |-> ((r_out.slot != '0) == r_out.slot_valid))
        else $error("slot and slot_valid disagree");

    // apart from a start flag or the last word, a word moving on steps the index by one
    a_index_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && !r_in_start && (cur_index != ifcc_pkg::LAST_WORD) |=>
        cur_index == $past(cur_index) + 1'b1)
        else $error("word index did not step");
`endif

endmodule

[rtl/ifcc_crc_update.sv]
`timescale 1ns / 1ps
// Parallel reflected CRC-32 update over one 16-bit word.
module ifcc_crc_update (
    input  logic [ifcc_pkg::CRC_W-1:0]  i_crc,
    input  logic [ifcc_pkg::WORD_W-1:0] i_word,
    output logic [ifcc_pkg::CRC_W-1:0]  o_crc
);

    localparam ifcc_pkg::t_crc_cols Cols = ifcc_pkg::crc_cols();

    always_comb begin
        o_crc = '0;
        for (int j = 0; j < ifcc_pkg::CRC_W; j++) begin
            if (i_crc[j]) begin
                o_crc = o_crc ^ Cols[j];
            end
        end
        for (int k = 0; k < ifcc_pkg::WORD_W; k++) begin
            if (i_word[k]) begin
                o_crc = o_crc ^ Cols[ifcc_pkg::CRC_W+k];
            end
        end
    end

endmodule

[rtl/ifcc_frame_ctrl.sv]
`timescale 1ns / 1ps
// Frame tracking: word index, running CRC, slot decode and CRC check.
module ifcc_frame_ctrl (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_advance,
    input  logic [ifcc_pkg::WORD_W-1:0]  i_word,
    input  logic                         i_start,
    output ifcc_pkg::t_result            o_result,
    output logic [ifcc_pkg::IDX_W-1:0]   o_index
);

    logic [ifcc_pkg::IDX_W-1:0]  r_index, n_index;
    logic [ifcc_pkg::CRC_W-1:0]  r_crc, n_crc;
    logic [ifcc_pkg::WORD_W-1:0] r_rxcrc_low, n_rxcrc_low;

    logic [ifcc_pkg::IDX_W-1:0]  idx;
    logic [ifcc_pkg::CRC_W-1:0]  crc_in;
    logic [ifcc_pkg::CRC_W-1:0]  crc_upd;

    ifcc_crc_update u_crc (
        .i_crc  (crc_in),
        .i_word (i_word),
        .o_crc  (crc_upd)
    );

    always_comb begin
        // start flag or an unreachable index both mean word zero
        if (i_start || (r_index >= ifcc_pkg::FRAME_WORDS)) begin
            idx = '0;
        end else begin
            idx = r_index;
        end
        crc_in = (idx == '0) ? ifcc_pkg::CRC_INIT : r_crc;

        n_crc = crc_in;
        if ((idx >= ifcc_pkg::CRC_FIRST) && (idx <= ifcc_pkg::CRC_LAST)) begin
            n_crc = crc_upd;
        end

        n_rxcrc_low = r_rxcrc_low;
        if (idx == ifcc_pkg::RXCRC_LOW_IDX) begin
            n_rxcrc_low = i_word;
        end

        n_index = (idx == ifcc_pkg::LAST_WORD) ? '0 : idx + 1'b1;

        o_result.out_word   = i_word;
        o_result.slot       = '0;
        o_result.slot_valid = 1'b0;
        if (idx == ifcc_pkg::SLOT_SPECIAL) begin
            o_result.slot       = ifcc_pkg::SLOT_OF_WORD3;
            o_result.slot_valid = 1'b1;
        end else if ((idx >= ifcc_pkg::SLOT_FIRST) && (idx <= ifcc_pkg::SLOT_LAST)) begin
            o_result.slot       = ifcc_pkg::SLOT_W'(idx - ifcc_pkg::SLOT_OFFSET);
            o_result.slot_valid = 1'b1;
        end
        o_result.frame_done = (idx == ifcc_pkg::LAST_WORD);
        o_result.crc_ok     = (idx == ifcc_pkg::LAST_WORD) &&
                              ({i_word, r_rxcrc_low} == ~crc_in);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_index     <= '0;
            r_crc       <= ifcc_pkg::CRC_INIT;
            r_rxcrc_low <= '0;
        end else if (i_advance) begin
            r_index     <= n_index;
            r_crc       <= n_crc;
            r_rxcrc_low <= n_rxcrc_low;
        end
    end

    assign o_index = r_index;

endmodule

[tb/sv/tb_ifcc_crc_pkg.sv]
`timescale 1ns / 1ps
// Testbench package: reflected CRC-32 helpers shared by stimulus and checker.
package tb_ifcc_crc_pkg;

    import ifcc_pkg::*;

    function automatic logic [CRC_W-1:0] crc_add_byte(
        input logic [CRC_W-1:0] crc,
        input logic [7:0]       data
    );
        logic [CRC_W-1:0] r;
        r = crc ^ {24'd0, data};
        for (int i = 0; i < 8; i++) begin
            r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
        end
        return r;
    endfunction

    // Low byte goes in first.
    function automatic logic [CRC_W-1:0] crc_add_word(
        input logic [CRC_W-1:0]  crc,
        input logic [WORD_W-1:0] w
    );
        return crc_add_byte(crc_add_byte(crc, w[7:0]), w[15:8]);
    endfunction

endpackage

[tb/sv/tb_ifcc_frame_checker.sv]
`timescale 1ns / 1ps
// Checker: predicts each result word from accepted input words and compares.
module tb_ifcc_frame_checker (
    input  logic i_clk,
    input  logic i_rst_n,
    ifcc_in_if   i_in,
    ifcc_out_if  i_out,
    output int   o_fail_count,
    output int   o_pending
);
    import ifcc_pkg::*;
    import tb_ifcc_crc_pkg::*;

    logic [IDX_W-1:0]  frame_idx;
    logic [CRC_W-1:0]  frame_crc;
    logic [WORD_W-1:0] crc_low_half;
    t_result           expected_results[$];
    int                fails;

    function automatic t_result predict_frame_word(
        input logic [WORD_W-1:0] w,
        input logic              start
    );
        t_result          r;
        logic [IDX_W-1:0] idx;
        r            = '0;
        r.out_word   = w;
        idx          = start ? '0 : frame_idx;
        if (idx >= FRAME_WORDS) idx = '0;
        if (idx == '0) frame_crc = CRC_INIT;
        if (idx >= CRC_FIRST && idx <= CRC_LAST) frame_crc = crc_add_word(frame_crc, w);
        if (idx == SLOT_SPECIAL) begin
            r.slot       = SLOT_OF_WORD3;
            r.slot_valid = 1'b1;
        end else if (idx >= SLOT_FIRST && idx <= SLOT_LAST) begin
            r.slot       = SLOT_W'(idx - SLOT_OFFSET);
            r.slot_valid = 1'b1;
        end
        if (idx == RXCRC_LOW_IDX) crc_low_half = w;
        if (idx == LAST_WORD) begin
            r.frame_done = 1'b1;
            r.crc_ok     = ({w, crc_low_half} == ~frame_crc);
        end
        frame_idx = (idx == LAST_WORD) ? '0 : idx + 1'b1;
        return r;
    endfunction

    task automatic report(input string field, input int exp_v, input int got_v);
        $display("%0t ns: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, got_v);
        fails++;
    endtask

    initial begin
        fails        = 0;
        o_fail_count = 0;
        o_pending    = 0;
    end

    always @(posedge i_clk) begin
        t_result exp_r;
        if (!i_rst_n) begin
            frame_idx    = '0;
            frame_crc    = CRC_INIT;
            crc_low_half = '0;
            expected_results.delete();
        end else begin
            if (i_in.valid && i_in.ready) begin
                expected_results.push_back(predict_frame_word(i_in.rx_word, i_in.frame_start));
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_results.size() == 0) begin
                    $display("%0t ns: result word 0x%0h with nothing expected",
                             $time, i_out.out_word);
                    fails++;
                end else begin
                    exp_r = expected_results.pop_front();
                    if (i_out.out_word !== exp_r.out_word)
                        report("out_word", exp_r.out_word, i_out.out_word);
                    if (i_out.slot !== exp_r.slot)
                        report("slot", exp_r.slot, i_out.slot);
                    if (i_out.slot_valid !== exp_r.slot_valid)
                        report("slot_valid", exp_r.slot_valid, i_out.slot_valid);
                    if (i_out.frame_done !== exp_r.frame_done)
                        report("frame_done", exp_r.frame_done, i_out.frame_done);
                    if (i_out.crc_ok !== exp_r.crc_ok)
                        report("crc_ok", exp_r.crc_ok, i_out.crc_ok);
                end
            end
        end
        o_fail_count <= fails;
        o_pending    <= expected_results.size();
    end

endmodule

[tb/sv/tb_imu_burst_frame_crc_checker_top.sv]
`timescale 1ns / 1ps
// Testbench top: clock, reset, frame stimulus, sink stalls and the verdict.
module tb_imu_burst_frame_crc_checker_top;
    import ifcc_pkg::*;
    import tb_ifcc_crc_pkg::*;

    localparam int ITEMS      = 400;
    localparam int CALM_TAIL  = 60;      // last words run with no idling at all
    localparam int CYCLE_CAP  = 200000;  // hard stop for a hung run
    localparam int DRAIN_CAP  = 2000;
    localparam int TAIL_WAIT  = 10;      // extra margin after draining

    logic i_clk;
    logic i_rst_n;
    int   fail_count;
    int   pending;
    int   words_sent;
    int   cycle_count;
    bit   idle_on;
    bit   stall_on;

    ifcc_in_if  in_ch();
    ifcc_out_if out_ch();

    imu_burst_frame_crc_checker_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    tb_ifcc_frame_checker frame_chk (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #1 i_clk = ~i_clk;

    // Hard stop if the pipeline hangs.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_CAP) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("*** FAILED ***");
        $finish;
    end

    // Result side: ready drops in random bursts while stall_on.
    initial begin
        int stall_left;
        stall_left = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_on && stall_left == 0 && $urandom_range(0, 7) == 0)
                stall_left = $urandom_range(1, 16);
            if (stall_left > 0) begin
                out_ch.ready <= 1'b0;
                stall_left--;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Offer one word and hold it until the block takes it. Returns in the
    // step of the accepting edge, possibly after an idle burst.
    task automatic send_word(input logic [WORD_W-1:0] w, input logic start);
        in_ch.valid       <= 1'b1;
        in_ch.rx_word     <= w;
        in_ch.frame_start <= start;
        do @(posedge i_clk); while (!in_ch.ready);
        words_sent++;
        if (idle_on && $urandom_range(0, 5) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 16)) @(posedge i_clk);
        end
    endtask

    // Sends the first n_words of a frame. Words 17/18 carry the inverted CRC
    // of words 2..16, optionally with one bit flipped so the check fails.
    // extremes fills the other words with alternating all-zero / all-one.
    task automatic send_frame(
        input bit flag_start,
        input bit extremes,
        input bit spoil_crc,
        input int n_words
    );
        logic [CRC_W-1:0]  crc;
        logic [CRC_W-1:0]  rx_crc;
        logic [WORD_W-1:0] w;
        crc    = CRC_INIT;
        rx_crc = '0;
        for (int k = 0; k < n_words; k++) begin
            if (k == int'(RXCRC_LOW_IDX)) begin
                rx_crc = ~crc;
                if (spoil_crc) rx_crc[$urandom_range(0, CRC_W-1)] ^= 1'b1;
                w = rx_crc[15:0];
            end else if (k == int'(LAST_WORD)) begin
                w = rx_crc[31:16];
            end else if (extremes) begin
                w = k[0] ? 16'hFFFF : 16'h0000;
            end else begin
                w = WORD_W'($urandom);
            end
            if (k >= int'(CRC_FIRST) && k <= int'(CRC_LAST)) crc = crc_add_word(crc, w);
            send_word(w, flag_start && k == 0);
        end
    endtask

    // Sender holds off until every result in flight has come back.
    task automatic wait_drained();
        int n;
        n = 0;
        in_ch.valid <= 1'b0;
        do begin
            @(posedge i_clk);
            n++;
        end while (pending != 0 && n < DRAIN_CAP);
    endtask

    initial begin
        int  pick;
        bit  at_boundary;
        words_sent         = 0;
        idle_on            = 1'b1;
        stall_on           = 1'b1;
        i_rst_n           <= 1'b0;
        in_ch.valid       <= 1'b0;
        in_ch.rx_word     <= '0;
        in_ch.frame_start <= 1'b0;
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: a frame cut short after a few words, then restarted by the
        // start flag mid-count; the restart must begin with a clean CRC.
        send_word(16'hFFFF, 1'b1);
        send_word(16'h0000, 1'b0);
        send_word(16'hA5A5, 1'b0);
        send_word(16'h5A5A, 1'b0);
        send_frame(1'b1, 1'b1, 1'b0, 19);
        // Let the pipeline run dry once before the random part.
        wait_drained();
        at_boundary = 1'b1;

        // Random: mostly well-formed frames, some with bad CRC, some cut
        // short, some loose noise words with stray start flags.
        while (words_sent < ITEMS) begin
            if (words_sent >= ITEMS - CALM_TAIL) begin
                idle_on  = 1'b0;
                stall_on = 1'b0;
            end else begin
                idle_on  = ($urandom_range(0, 3) != 0);
                stall_on = ($urandom_range(0, 3) != 0);
            end
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
                // back-to-back frames may rely on the index wrap
                send_frame(at_boundary ? 1'($urandom_range(0, 1)) : 1'b1,
                           $urandom_range(0, 19) == 0, 1'b0, 19);
                at_boundary = 1'b1;
            end else if (pick < 75) begin
                send_frame(1'b1, 1'b0, 1'b1, 19);
                at_boundary = 1'b1;
            end else if (pick < 88) begin
                send_frame(1'b1, 1'b0, 1'b0, $urandom_range(1, 18));
                at_boundary = 1'b0;
            end else begin
                repeat ($urandom_range(1, 8))
                    send_word(WORD_W'($urandom), $urandom_range(0, 7) == 0);
                at_boundary = 1'b0;
            end
        end

        wait_drained();
        repeat (TAIL_WAIT) @(posedge i_clk);
        if (fail_count == 0 && pending == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
